// File: sv/wfs_pkg.sv
`timescale 1ns / 1ps

package wfs_pkg;

  // Width of the angle field on the input stream.
  localparam int ANGLE_BITS = 24;

  // Width of the waveform mode register.
  localparam int MODE_BITS = 3;

  // Waveform selection codes.
  typedef enum logic [MODE_BITS-1:0] {
    MODE_PARABOLIC   = 3'd0,
    MODE_SQUARE_ROOT = 3'd1,
    MODE_TRIANGLE    = 3'd2,
    MODE_SAWTOOTH    = 3'd3,
    MODE_SQUARE_HALF = 3'd4,
    MODE_RAMP_SQUARE = 3'd5
  } wfs_mode_e;

endpackage

// File: sv/waveform_shaper.sv
`timescale 1ns / 1ps

// Phase-to-waveform shaper. Each angle on the input stream gives one Q1.15
// style sample of the waveform chosen by the mode register: parabolic,
// square-root, triangle, sawtooth, half-amplitude square or ramped square.
// The block takes one request per clock unless the output stalls, and
// returns results in order. The pipeline is two front stages for phase
// reduction and per-mode arithmetic, a chain of SAMPLE_BITS + 1 root cells
// that each resolve one bit of the square root, and the output register.
// Every request passes the whole chain, so the latency is the same in all
// modes. Back-pressure on the output holds the pipeline in place while
// empty stages keep filling. The mode register resets to triangle and
// should be written only while no request is in flight; codes six and
// seven give a zero sample.
module waveform_shaper #(
  parameter int PHASE_BITS  = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Configuration: waveform_mode
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [wfs_pkg::MODE_BITS-1:0]          cfg_data_i,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // Fields from bit 0: angle
  input  logic [wfs_pkg::ANGLE_BITS-1:0]         s_axis_tdata_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // Fields from bit 0: sample, then zero padding to a whole byte
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_axis_tdata_o
);

  import wfs_pkg::*;

  localparam int NW  = SAMPLE_BITS + 1;
  localparam int XW  = 2 * NW;
  localparam int VW  = SAMPLE_BITS + 2;
  localparam int SW  = VW + 1;
  localparam int TDW = ((SAMPLE_BITS + 7) / 8) * 8;

  localparam logic signed [VW-1:0] ONE_V = VW'(64'd1 << (SAMPLE_BITS-1));
  localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [SAMPLE_BITS-1:0] S_HALF_POS = SAMPLE_BITS'(64'd1 << (SAMPLE_BITS-2));
  localparam logic [SAMPLE_BITS-1:0] S_HALF_NEG = ~S_HALF_POS + 1'b1;

  logic [MODE_BITS-1:0] mode_q;

  logic          chain_valid [0:NW];
  logic          chain_ready [0:NW];
  logic [XW-1:0] chain_x     [0:NW];
  logic [NW:0]   chain_rem   [0:NW];
  logic [NW-1:0] chain_root  [0:NW];
  logic [SW-1:0] chain_side  [0:NW];

  logic                   front_is_sqrt;
  logic signed [VW-1:0]   front_pre;
  logic signed [VW-1:0]   fin;
  logic                   fin_is_sqrt;
  logic signed [VW-1:0]   fin_pre;
  logic                   m_valid_q;
  logic [SAMPLE_BITS-1:0] sample_q, sample_d;

  // Mode register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_TRIANGLE;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

  // Phase reduction and per-mode arithmetic.
  wfs_front #(
    .PHASE_BITS  (PHASE_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .angle_i     (s_axis_tdata_i),
    .mode_i      (mode_q),
    .out_valid_o (chain_valid[0]),
    .out_ready_i (chain_ready[0]),
    .x_o         (chain_x[0]),
    .is_sqrt_o   (front_is_sqrt),
    .pre_o       (front_pre)
  );

  assign chain_rem[0]  = '0;
  assign chain_root[0] = '0;
  assign chain_side[0] = {front_is_sqrt, front_pre};

  // Square-root chain, one result bit per cell.
  for (genvar k = 0; k < NW; k++) begin : g_cell
    wfs_cell #(
      .XW (XW),
      .NW (NW),
      .SW (SW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[k]),
      .ready_o (chain_ready[k]),
      .x_i     (chain_x[k]),
      .rem_i   (chain_rem[k]),
      .root_i  (chain_root[k]),
      .side_i  (chain_side[k]),
      .valid_o (chain_valid[k+1]),
      .ready_i (chain_ready[k+1]),
      .x_o     (chain_x[k+1]),
      .rem_o   (chain_rem[k+1]),
      .root_o  (chain_root[k+1]),
      .side_o  (chain_side[k+1])
    );
  end

  // Final value selection and saturation of plus one.
  always_comb begin
    fin_is_sqrt = chain_side[NW][SW-1];
    fin_pre     = $signed(chain_side[NW][VW-1:0]);
    fin = fin_is_sqrt ? ($signed(VW'(chain_root[NW])) - ONE_V) : fin_pre;
    if (fin >= ONE_V) begin
      sample_d = S_MAX;
    end else if (fin < -ONE_V) begin
      sample_d = S_MIN;
    end else begin
      sample_d = fin[SAMPLE_BITS-1:0];
    end
  end

  // Output register.
  assign chain_ready[NW] = !m_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (chain_ready[NW]) begin
      m_valid_q <= chain_valid[NW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (chain_ready[NW] && chain_valid[NW]) begin
      sample_q <= sample_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = TDW'(sample_q);

  // A result leaving the chain is always captured by the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chain_valid[NW] && chain_ready[NW]) |=> m_valid_q)
    else $error("result from chain not captured");

  // The half square mode only ever yields plus or minus one half.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && mode_q == MODE_SQUARE_HALF) |->
      (sample_q == S_HALF_POS || sample_q == S_HALF_NEG))
    else $error("half square sample out of set");

  // The end of the chain holds its request while the output is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chain_valid[NW] && !chain_ready[NW]) |=> chain_valid[NW])
    else $error("chain end dropped a stalled request");

endmodule

// File: sv/wfs_front.sv
`timescale 1ns / 1ps

module wfs_front #(
  parameter int PHASE_BITS  = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [wfs_pkg::ANGLE_BITS-1:0]     angle_i,
  input  logic [wfs_pkg::MODE_BITS-1:0]      mode_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [2*SAMPLE_BITS+1:0]           x_o,
  output logic                               is_sqrt_o,
  output logic signed [SAMPLE_BITS+1:0]      pre_o
);

  import wfs_pkg::*;

  localparam int UW   = SAMPLE_BITS + 1;
  localparam int VW   = SAMPLE_BITS + 2;
  localparam int XW   = 2 * SAMPLE_BITS + 2;
  localparam int SQW  = 2 * PHASE_BITS;
  localparam int P10W = PHASE_BITS + 4;

  localparam logic [PHASE_BITS-1:0] HALF = {1'b1, {(PHASE_BITS-1){1'b0}}};
  localparam logic [P10W-1:0] HALF9  = P10W'(64'd9 << (PHASE_BITS-1));
  localparam logic [P10W-1:0] HALF10 = P10W'(64'd10 << (PHASE_BITS-1));
  localparam logic [P10W-1:0] HALF19 = P10W'(64'd19 << (PHASE_BITS-1));

  localparam logic signed [VW-1:0] ONE_V  = VW'(64'd1 << (SAMPLE_BITS-1));
  localparam logic signed [VW-1:0] HALF_V = VW'(64'd1 << (SAMPLE_BITS-2));

  // Scale factors as left and right shift amounts.
  localparam int SH0  = SAMPLE_BITS - 2*PHASE_BITS + 2;
  localparam int SH0L = (SH0 > 0) ? SH0 : 0;
  localparam int SH0R = (SH0 < 0) ? -SH0 : 0;
  localparam int W0   = SQW + SH0L;
  localparam int SH1  = 2*SAMPLE_BITS - PHASE_BITS + 1;
  localparam int SH1L = (SH1 > 0) ? SH1 : 0;
  localparam int SH1R = (SH1 < 0) ? -SH1 : 0;
  localparam int W1   = PHASE_BITS + SH1L;
  localparam int SH2  = SAMPLE_BITS - PHASE_BITS + 1;
  localparam int SH2L = (SH2 > 0) ? SH2 : 0;
  localparam int SH2R = (SH2 < 0) ? -SH2 : 0;
  localparam int W2   = PHASE_BITS + SH2L;
  localparam int SH3  = SAMPLE_BITS - PHASE_BITS;
  localparam int SH3L = (SH3 > 0) ? SH3 : 0;
  localparam int SH3R = (SH3 < 0) ? -SH3 : 0;
  localparam int W3   = PHASE_BITS + SH3L + 1;
  localparam logic [W3-1:0] M3 = W3'((64'd1 << SH3R) - 64'd1);

  logic                              a_ready;
  logic                              a_valid_q;
  logic [PHASE_BITS-1:0]             a_p_q, a_p_d;
  logic [PHASE_BITS-1:0]             a_e_q, a_e_d;
  logic [ANGLE_BITS-1:0]             mag;

  logic                              b_ready;
  logic                              b_valid_q;
  logic [XW-1:0]                     b_x_q, b_x_d;
  logic                              b_is_sqrt_q, b_is_sqrt_d;
  logic signed [VW-1:0]              b_pre_q, b_pre_d;

  logic [SQW-1:0]                    sq;
  logic [UW-1:0]                     u0, u2, u3;
  logic [P10W-1:0]                   p10;
  logic                              ramp_fall, ramp_rise;
  logic [PHASE_BITS-1:0]             e5, e_tri;
  logic signed [VW-1:0]              v_tri;

  // Stage A: magnitude, reduction to one period, distance from the half point.
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  always_comb begin
    mag   = angle_i[ANGLE_BITS-1] ? (~angle_i + 1'b1) : angle_i;
    a_p_d = mag[PHASE_BITS-1:0];
    a_e_d = (a_p_d >= HALF) ? (a_p_d - HALF) : (HALF - a_p_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_p_q <= a_p_d;
      a_e_q <= a_e_d;
    end
  end

  // Stage B: per-mode arithmetic and the operand for the root chain.
  assign b_ready = !b_valid_q || out_ready_i;

  always_comb begin
    sq  = SQW'(a_e_q) * SQW'(a_e_q);
    u0  = UW'((W0'(sq) << SH0L) >> SH0R);
    u3  = UW'(((W3'(a_p_q) << SH3L) + M3) >> SH3R);
    p10 = (P10W'(a_p_q) << 3) + (P10W'(a_p_q) << 1);

    // Ramp windows at the end of each half period.
    ramp_fall = (p10 >= HALF9) && (a_p_q <= HALF);
    ramp_rise = (p10 >= HALF19);
    e5 = ramp_fall ? PHASE_BITS'(HALF10 - p10) : PHASE_BITS'(p10 - HALF19);

    // The triangle map is shared by the triangle and the ramped square.
    e_tri = (mode_i == MODE_RAMP_SQUARE) ? e5 : a_e_q;
    u2    = UW'((W2'(e_tri) << SH2L) >> SH2R);
    v_tri = $signed(VW'(u2)) - ONE_V;

    b_x_d       = XW'((W1'(a_e_q) << SH1L) >> SH1R);
    b_is_sqrt_d = 1'b0;
    case (mode_i)
      MODE_PARABOLIC: begin
        b_pre_d = $signed(VW'(u0)) - ONE_V;
      end
      MODE_SQUARE_ROOT: begin
        b_pre_d     = '0;
        b_is_sqrt_d = 1'b1;
      end
      MODE_TRIANGLE: begin
        b_pre_d = v_tri;
      end
      MODE_SAWTOOTH: begin
        b_pre_d = ONE_V - $signed(VW'(u3));
      end
      MODE_SQUARE_HALF: begin
        b_pre_d = (a_p_q < HALF) ? HALF_V : -HALF_V;
      end
      MODE_RAMP_SQUARE: begin
        if (ramp_fall || ramp_rise) begin
          b_pre_d = v_tri;
        end else begin
          b_pre_d = (a_p_q < HALF) ? ONE_V : -ONE_V;
        end
      end
      default: begin
        b_pre_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      b_x_q       <= b_x_d;
      b_is_sqrt_q <= b_is_sqrt_d;
      b_pre_q     <= b_pre_d;
    end
  end

  assign out_valid_o = b_valid_q;
  assign x_o         = b_x_q;
  assign is_sqrt_o   = b_is_sqrt_q;
  assign pre_o       = b_pre_q;

  // The distance from the half point never exceeds a half period.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q |-> (a_e_q <= HALF))
    else $error("phase distance above half period");

  // A stalled stage B keeps its request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && !out_ready_i) |=> b_valid_q)
    else $error("stage B dropped a stalled request");

  // The root operand is only flagged for the square-root mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_ready && a_valid_q && mode_i != MODE_SQUARE_ROOT) |=> !b_is_sqrt_q)
    else $error("root flag set outside square-root mode");

endmodule

// File: sv/wfs_cell.sv
`timescale 1ns / 1ps

module wfs_cell #(
  parameter int XW = 34,
  parameter int NW = 17,
  parameter int SW = 19
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic [XW-1:0] x_i,
  input  logic [NW:0]   rem_i,
  input  logic [NW-1:0] root_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [XW-1:0] x_o,
  output logic [NW:0]   rem_o,
  output logic [NW-1:0] root_o,
  output logic [SW-1:0] side_o
);

  logic          valid_q;
  logic [XW-1:0] x_q, x_d;
  logic [NW:0]   rem_q, rem_d;
  logic [NW-1:0] root_q, root_d;
  logic [SW-1:0] side_q;
  logic [NW+2:0] rem_sh, trial;
  logic          take;

  // One root digit: bring down two operand bits and try to subtract.
  always_comb begin
    rem_sh = {rem_i, x_i[XW-1 -: 2]};
    trial  = (NW+3)'({root_i, 2'b01});
    take   = (rem_sh >= trial);
    rem_d  = take ? (NW+1)'(rem_sh - trial) : (NW+1)'(rem_sh);
    root_d = {root_i[NW-2:0], take};
    x_d    = {x_i[XW-3:0], 2'b00};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      x_q    <= x_d;
      rem_q  <= rem_d;
      root_q <= root_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

  // The partial remainder stays within twice the partial root.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (rem_q <= {root_q, 1'b0}))
    else $error("root remainder out of range");

  // A stalled cell keeps its request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !ready_i) |=> valid_q)
    else $error("cell dropped a stalled request");

  // An accepted request always lands in the cell.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && ready_o) |=> valid_q)
    else $error("cell lost an accepted request");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import wfs_pkg::*;

  // Mode codes the package leaves unnamed; both must give a zero sample.
  localparam logic [MODE_BITS-1:0] MODE_UNUSED_6 = 3'd6;
  localparam logic [MODE_BITS-1:0] MODE_UNUSED_7 = 3'd7;

  localparam longint ONE  = 32768;
  localparam longint HALF = 32768;

  // Latency of the shaper plus some slack, used before mode writes, in one sender pause and at the end.
  localparam int PIPE_LATENCY = 24;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 120;
  localparam int PHASE_ITEMS  = 80;

  typedef struct packed {
    logic [MODE_BITS-1:0] mode;
    logic [23:0]          angle;
    logic                 known;
    logic [15:0]          sample;
  } shape_row_t;

  // Directed requests. Where known is set the sample is typed in; otherwise it
  // comes from the predictor.
  localparam shape_row_t DIRECTED_ROWS [24] = '{
    '{MODE_TRIANGLE,    24'h000000, 1'b1, 16'h7FFF},
    '{MODE_TRIANGLE,    24'h008000, 1'b1, 16'h8000},
    '{MODE_TRIANGLE,    24'h800000, 1'b1, 16'h7FFF},
    '{MODE_TRIANGLE,    24'h7FFFFF, 1'b1, 16'h7FFE},
    '{MODE_TRIANGLE,    24'hFFFFFF, 1'b1, 16'h7FFE},
    '{MODE_TRIANGLE,    24'hFF8000, 1'b1, 16'h8000},
    '{MODE_PARABOLIC,   24'h000000, 1'b1, 16'h7FFF},
    '{MODE_PARABOLIC,   24'h008000, 1'b1, 16'h8000},
    '{MODE_PARABOLIC,   24'h004000, 1'b1, 16'hC000},
    '{MODE_SQUARE_ROOT, 24'h000000, 1'b1, 16'h7FFF},
    '{MODE_SQUARE_ROOT, 24'h008000, 1'b1, 16'h8000},
    '{MODE_SQUARE_ROOT, 24'h006000, 1'b1, 16'h0000},
    '{MODE_SAWTOOTH,    24'h000000, 1'b1, 16'h7FFF},
    '{MODE_SAWTOOTH,    24'h008000, 1'b1, 16'h0000},
    '{MODE_SAWTOOTH,    24'h00FFFF, 1'b1, 16'h8001},
    '{MODE_SQUARE_HALF, 24'h000000, 1'b1, 16'h4000},
    '{MODE_SQUARE_HALF, 24'h007FFF, 1'b1, 16'h4000},
    '{MODE_SQUARE_HALF, 24'h008000, 1'b1, 16'hC000},
    '{MODE_RAMP_SQUARE, 24'h000000, 1'b1, 16'h7FFF},
    '{MODE_RAMP_SQUARE, 24'h007334, 1'b0, 16'h0000},
    '{MODE_RAMP_SQUARE, 24'h008000, 1'b1, 16'h8000},
    '{MODE_RAMP_SQUARE, 24'h00F334, 1'b0, 16'h0000},
    '{MODE_UNUSED_6,    24'h003039, 1'b1, 16'h0000},
    '{MODE_UNUSED_7,    24'hFFFFFB, 1'b1, 16'h0000}
  };

  // Mode of each random phase; the last one runs without idling.
  localparam logic [MODE_BITS-1:0] PHASE_MODES [8] = '{
    MODE_RAMP_SQUARE, MODE_PARABOLIC, MODE_SAWTOOTH, MODE_UNUSED_6,
    MODE_SQUARE_ROOT, MODE_SQUARE_HALF, MODE_UNUSED_7, MODE_TRIANGLE
  };

  // Phases where the waveform changes shape: 0, 0.9 half, half, 1.9 half, full.
  localparam int unsigned PHASE_EDGES [9] = '{
    0, 29491, 29492, 32767, 32768, 32769, 62259, 62260, 65535
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [MODE_BITS-1:0] cfg_data_i;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [23:0]          s_axis_tdata_i;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [15:0]          m_axis_tdata_o;

  logic [MODE_BITS-1:0] shaper_mode = MODE_TRIANGLE;
  logic [15:0]          sample_q [$];
  logic [15:0]          want_sample;
  bit                   idle_on = 1'b0;
  bit                   hold_req = 1'b0;
  int                   fail_count = 0;
  int                   cycle_count = 0;

  waveform_shaper u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Triangle level for a distance e from the half period: 2e/H - 1 in Q1.15.
  function automatic longint slope_level(input longint e);
    return (e <<< 1) - ONE;
  endfunction

  // Floor of the square root, one bit at a time from the top.
  function automatic longint unsigned root_floor(input longint unsigned x);
    longint unsigned r;
    longint unsigned trial;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = r | (64'd1 << b);
      if (trial * trial <= x) r = trial;
    end
    return r;
  endfunction

  // Expected sample for one angle under the given mode.
  function automatic logic [15:0] shape_sample(input logic [MODE_BITS-1:0] mode,
                                               input logic [23:0] angle);
    logic [24:0] mag;
    longint      p;
    longint      e;
    longint      v;
    // The most negative angle keeps its magnitude 2^23 in the wider vector.
    mag = angle[23] ? (25'h1000000 - {1'b0, angle}) : {1'b0, angle};
    p = longint'(mag[15:0]);
    e = (p >= HALF) ? p - HALF : HALF - p;
    case (mode)
      MODE_PARABOLIC:   v = ((e * e) >>> 14) - ONE;
      MODE_SQUARE_ROOT: v = longint'(root_floor(longint'(e) << 17)) - ONE;
      MODE_TRIANGLE:    v = slope_level(e);
      MODE_SAWTOOTH:    v = ONE - p;
      MODE_SQUARE_HALF: v = (p < HALF) ? ONE / 2 : -(ONE / 2);
      MODE_RAMP_SQUARE: begin
        if (10 * p >= 9 * HALF && p <= HALF) v = slope_level(10 * HALF - 10 * p);
        else if (10 * p >= 19 * HALF) v = slope_level(10 * p - 19 * HALF);
        else v = (p < HALF) ? ONE : -ONE;
      end
      default: v = 0;
    endcase
    // Plus one does not fit in Q1.15 and clips to the largest code.
    if (v > ONE - 1) v = ONE - 1;
    if (v < -ONE) v = -ONE;
    return v[15:0];
  endfunction

  function automatic logic [23:0] pick_angle();
    logic [23:0] a;
    case ($urandom_range(0, 3))
      0: a = 24'($urandom);
      1: a = {8'($urandom), 16'(PHASE_EDGES[$urandom_range(0, 8)] + $urandom_range(0, 4) - 2)};
      2: begin
        case ($urandom_range(0, 4))
          0: a = 24'h800000;
          1: a = 24'h7FFFFF;
          2: a = 24'h800001;
          3: a = 24'hFFFFFF;
          default: a = 24'h000000;
        endcase
      end
      default: begin
        a = 24'($urandom_range(0, 65535));
        if ($urandom_range(0, 1) == 1) a = -a;
      end
    endcase
    return a;
  endfunction

  // Offer one angle, with an occasional gap first; returns at the falling edge
  // after the request was taken, with tvalid still high.
  task automatic send_angle(input logic [23:0] angle, input logic known,
                            input logic [15:0] sample);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tdata_i  = angle;
    s_axis_tvalid_i = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sample_q.push_back(known ? sample : shape_sample(shaper_mode, angle));
    @(negedge clk_i);
  endtask

  // Wait until every pending sample has come back and the pipeline is empty.
  task automatic wait_drained();
    s_axis_tvalid_i = 1'b0;
    while (sample_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY) @(negedge clk_i);
  endtask

  task automatic write_mode(input logic [MODE_BITS-1:0] mode);
    cfg_data_i  = mode;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    shaper_mode = mode;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Stimulus: directed rows, then one random phase per mode.
  initial begin
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].mode != shaper_mode) begin
        wait_drained();
        write_mode(DIRECTED_ROWS[i].mode);
      end
      send_angle(DIRECTED_ROWS[i].angle, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].sample);
    end

    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      write_mode(PHASE_MODES[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 20 == 0) idle_on = (ph != 7) && ($urandom_range(0, 3) != 0);
        // Long output stall while requests keep coming, so the input backs up.
        if (ph == 2 && n == 10) hold_req = 1'b1;
        // Sender pause until all outstanding samples are back.
        if (ph == 4 && n == 40) wait_drained();
        send_angle(pick_angle(), 1'b0, '0);
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Output side: random short stalls, and one long hold when requested.
  initial begin : rx_side
    int hold_left;
    int gap_left;
    hold_left = 0;
    gap_left  = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i = 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        m_axis_tready_i = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        gap_left = $urandom_range(0, 3);
        m_axis_tready_i = 1'b0;
      end else begin
        m_axis_tready_i = 1'b1;
      end
    end
  end

  // Compare each delivered sample with the oldest pending one.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (sample_q.size() == 0) begin
        $error("sample: expected nothing, actual %0d", $signed(m_axis_tdata_o[15:0]));
        fail_count++;
      end else begin
        want_sample = sample_q.pop_front();
        if (m_axis_tdata_o[15:0] !== want_sample) begin
          $error("sample: expected %0d, actual %0d", $signed(want_sample),
                 $signed(m_axis_tdata_o[15:0]));
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

endmodule

// File: waveform_shaper.f
sv/wfs_pkg.sv
sv/wfs_front.sv
sv/wfs_cell.sv
sv/waveform_shaper.sv
tb/tb_top.sv
